// ===== design/rc4_pkg.sv =====
`default_nettype none

package rc4_pkg;

    // Byte-wide payload and S-box geometry
    typedef logic [7:0] byte_t;

    localparam int SBOX_DEPTH = 256;
    localparam int SBOX_ADDR_W = $clog2(SBOX_DEPTH);
    localparam logic [SBOX_ADDR_W-1:0] SBOX_LAST = SBOX_ADDR_W'(SBOX_DEPTH - 1);

    // Key store sizing
    localparam int KEY_MAX_BYTES = 256;
    localparam int KEY_ADDR_W = $clog2(KEY_MAX_BYTES);
    localparam int KEY_CNT_W = $clog2(KEY_MAX_BYTES + 1);
    localparam logic [KEY_CNT_W-1:0] KEY_MAX_CNT = KEY_CNT_W'(KEY_MAX_BYTES);

    // Request codes
    typedef logic [1:0] req_code_t;
    localparam req_code_t REQ_KEY  = 2'd0;
    localparam req_code_t REQ_DATA = 2'd1;
    localparam req_code_t REQ_SKIP = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KS_READ_J,
        ST_KS_SWAP_I,
        ST_KS_SWAP_J,
        ST_SCH_READ_N,
        ST_SCH_READ_ACC,
        ST_SCH_SWAP_N,
        ST_SCH_SWAP_ACC
    } rc4_state_t;

endpackage

`default_nettype wire

// ===== design/rc4_if.sv =====
`default_nettype none

// Request channel: key, data or skip transactions
interface rc4_req_if;
    logic               valid;
    logic               ready;
    rc4_pkg::req_code_t req_type;
    rc4_pkg::byte_t     byte_in;
    logic               last_item;

    modport source (output valid, output req_type, output byte_in, output last_item,
                    input ready);
    modport sink   (input valid, input req_type, input byte_in, input last_item,
                    output ready);
endinterface

// Response channel: one transaction per data byte
interface rc4_rsp_if;
    logic           valid;
    logic           ready;
    rc4_pkg::byte_t byte_out;
    rc4_pkg::byte_t keystream_byte;

    modport source (output valid, output byte_out, output keystream_byte, input ready);
    modport sink   (input valid, input byte_out, input keystream_byte, output ready);
endinterface

`default_nettype wire

// ===== design/rc4_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port (read-old)
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/rc4_stream_cipher.sv =====
`default_nettype none

// RC4 stream cipher engine. Send key bytes as REQ_KEY transactions (bytes past 256 are dropped)
// and flag the final one with last_item; that transaction starts the key schedule, which keeps the
// request channel busy while, for every S-box entry, it reads S[n], reads S[acc] and writes the pair
// back swapped. A REQ_DATA transaction returns byte_out = byte_in ^ keystream and the keystream
// byte; REQ_SKIP advances the keystream with no response. Each data or skip transaction occupies
// the block while it works through the single S-box RAM read and write ports: read S[i], read
// S[j], write S[i] while reading the output index, then write S[j]. The response sits in an
// output register, so a stalled response channel only holds the engine when the next data byte
// is ready to be delivered. After reset the S-box is the identity permutation at once (per-entry
// valid bits, no clearing sweep); request code 3 is accepted and ignored.
module rc4_stream_cipher (
    input wire logic     clk,
    input wire logic     rst_n,
    rc4_req_if.sink      req,
    rc4_rsp_if.source    rsp
);

    rc4_pkg::rc4_state_t state_reg, state_next;

    // Stream indices and key bookkeeping
    rc4_pkg::byte_t                      i_reg, j_reg;
    logic [rc4_pkg::KEY_CNT_W-1:0]       key_count_reg;
    logic [rc4_pkg::SBOX_DEPTH-1:0]      sv_valid_reg;

    // Per-step working registers
    rc4_pkg::byte_t                      si_reg, sj_reg, t_reg, byte_reg;
    logic                                data_reg;
    logic [rc4_pkg::SBOX_ADDR_W-1:0]     n_reg;
    rc4_pkg::byte_t                      acc_reg, sn_reg;
    logic [rc4_pkg::KEY_ADDR_W-1:0]      kidx_reg;

    // Read-side tracking for the S-box
    logic [rc4_pkg::SBOX_ADDR_W-1:0]     rd_addr_reg;
    logic                                rd_hit_reg;

    // Output register
    logic                                out_valid_reg;
    rc4_pkg::byte_t                      byte_out_reg, keystream_reg;

    // Combinational controls
    logic                                req_fire;
    logic                                key_store_ok;
    logic                                stall;
    logic                                out_load;
    logic                                kidx_last;
    logic [rc4_pkg::KEY_CNT_W-1:0]       key_len;
    rc4_pkg::byte_t                      add_a, add_b, add_c, add_sum;
    rc4_pkg::byte_t                      ks;

    logic                                sbox_we;
    logic [rc4_pkg::SBOX_ADDR_W-1:0]     sbox_waddr, sbox_raddr;
    rc4_pkg::byte_t                      sbox_wdata, sbox_q, sbox_rd;
    logic                                key_we;
    rc4_pkg::byte_t                      key_q;

    // S-box and key store memories
    rc4_ram #(
        .WIDTH (8),
        .DEPTH (rc4_pkg::SBOX_DEPTH)
    ) u_sbox_ram (
        .clk   (clk),
        .we    (sbox_we),
        .waddr (sbox_waddr),
        .wdata (sbox_wdata),
        .raddr (sbox_raddr),
        .rdata (sbox_q)
    );

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (rc4_pkg::KEY_MAX_BYTES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_count_reg[rc4_pkg::KEY_ADDR_W-1:0]),
        .wdata (req.byte_in),
        .raddr (kidx_reg),
        .rdata (key_q)
    );

    // Handshake and status
    assign req.ready      = (state_reg == rc4_pkg::ST_IDLE);
    assign req_fire       = req.valid && req.ready;
    assign key_store_ok   = (key_count_reg < rc4_pkg::KEY_MAX_CNT);
    assign key_we         = req_fire && (req.req_type == rc4_pkg::REQ_KEY) && key_store_ok;
    assign stall          = data_reg && out_valid_reg && !rsp.ready;

    // Unwritten S-box entries read as their own address
    assign sbox_rd        = rd_hit_reg ? sbox_q : rd_addr_reg;

    // Key index wraps at the key length
    assign key_len        = (key_count_reg == '0) ? rc4_pkg::KEY_CNT_W'(1) : key_count_reg;
    assign kidx_last      = (rc4_pkg::KEY_CNT_W'(kidx_reg) + rc4_pkg::KEY_CNT_W'(1)) == key_len;

    // Shared 8-bit adder
    assign add_sum        = add_a + add_b + add_c;

    // Forward the swapped values into the keystream read
    assign ks = (t_reg == j_reg) ? si_reg :
                (t_reg == i_reg) ? sj_reg : sbox_rd;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.req_type == rc4_pkg::REQ_KEY)
                    begin
                        if (req.last_item)
                        begin
                            state_next = rc4_pkg::ST_SCH_READ_N;
                        end
                    end
                    else if (req.req_type inside {rc4_pkg::REQ_DATA, rc4_pkg::REQ_SKIP})
                    begin
                        state_next = rc4_pkg::ST_KS_READ_J;
                    end
                end
            end
            rc4_pkg::ST_KS_READ_J:    state_next = rc4_pkg::ST_KS_SWAP_I;
            rc4_pkg::ST_KS_SWAP_I:    state_next = rc4_pkg::ST_KS_SWAP_J;
            rc4_pkg::ST_KS_SWAP_J:
            begin
                if (!stall)
                begin
                    state_next = rc4_pkg::ST_IDLE;
                end
            end
            rc4_pkg::ST_SCH_READ_N:   state_next = rc4_pkg::ST_SCH_READ_ACC;
            rc4_pkg::ST_SCH_READ_ACC: state_next = rc4_pkg::ST_SCH_SWAP_N;
            rc4_pkg::ST_SCH_SWAP_N:   state_next = rc4_pkg::ST_SCH_SWAP_ACC;
            rc4_pkg::ST_SCH_SWAP_ACC:
            begin
                state_next = (n_reg == rc4_pkg::SBOX_LAST) ? rc4_pkg::ST_IDLE
                                                           : rc4_pkg::ST_SCH_READ_N;
            end
            default:                  state_next = rc4_pkg::ST_IDLE;
        endcase
    end

    // Datapath controls: memory ports, adder operands, output load
    always_comb
    begin
        sbox_raddr = i_reg + 8'd1;
        sbox_we    = 1'b0;
        sbox_waddr = i_reg;
        sbox_wdata = sbox_rd;
        add_a      = j_reg;
        add_b      = sbox_rd;
        add_c      = '0;
        out_load   = 1'b0;
        case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                sbox_raddr = i_reg + 8'd1;
            end
            rc4_pkg::ST_KS_READ_J:
            begin
                add_a      = j_reg;
                add_b      = sbox_rd;
                sbox_raddr = add_sum;
            end
            rc4_pkg::ST_KS_SWAP_I:
            begin
                sbox_we    = 1'b1;
                sbox_waddr = i_reg;
                sbox_wdata = sbox_rd;
                add_a      = si_reg;
                add_b      = sbox_rd;
                sbox_raddr = add_sum;
            end
            rc4_pkg::ST_KS_SWAP_J:
            begin
                sbox_raddr = t_reg;
                if (!stall)
                begin
                    sbox_we    = 1'b1;
                    sbox_waddr = j_reg;
                    sbox_wdata = si_reg;
                    out_load   = data_reg;
                end
            end
            rc4_pkg::ST_SCH_READ_N:
            begin
                sbox_raddr = n_reg;
            end
            rc4_pkg::ST_SCH_READ_ACC:
            begin
                add_a      = acc_reg;
                add_b      = sbox_rd;
                add_c      = key_q;
                sbox_raddr = add_sum;
            end
            rc4_pkg::ST_SCH_SWAP_N:
            begin
                sbox_we    = 1'b1;
                sbox_waddr = n_reg;
                sbox_wdata = sbox_rd;
            end
            rc4_pkg::ST_SCH_SWAP_ACC:
            begin
                sbox_we    = 1'b1;
                sbox_waddr = acc_reg;
                sbox_wdata = sn_reg;
            end
            default:
            begin
                sbox_we = 1'b0;
            end
        endcase
    end

    // Control state: sequencer, indices, key count, valid bits, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4_pkg::ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            key_count_reg <= '0;
            sv_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Count stored key bytes, saturating at the store size
            if (key_we)
            begin
                key_count_reg <= key_count_reg + rc4_pkg::KEY_CNT_W'(1);
            end

            // Advance i on a keystream transaction, j once S[i] is back
            if (req_fire && (req.req_type inside {rc4_pkg::REQ_DATA, rc4_pkg::REQ_SKIP}))
            begin
                i_reg <= i_reg + 8'd1;
            end
            if (state_reg == rc4_pkg::ST_KS_READ_J)
            begin
                j_reg <= add_sum;
            end

            // Mark written entries; drop all at schedule start to restore identity
            if (req_fire && (req.req_type == rc4_pkg::REQ_KEY) && req.last_item)
            begin
                sv_valid_reg <= '0;
            end
            else if (sbox_we)
            begin
                sv_valid_reg[sbox_waddr] <= 1'b1;
            end

            // Clear indices and key count when the schedule finishes
            if ((state_reg == rc4_pkg::ST_SCH_SWAP_ACC) && (n_reg == rc4_pkg::SBOX_LAST))
            begin
                i_reg         <= '0;
                j_reg         <= '0;
                key_count_reg <= '0;
            end

            // Hold the response until taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= sbox_raddr;
        rd_hit_reg  <= sv_valid_reg[sbox_raddr];

        // Latch the transaction
        if (req_fire)
        begin
            byte_reg <= req.byte_in;
            data_reg <= (req.req_type == rc4_pkg::REQ_DATA);
            n_reg    <= '0;
            acc_reg  <= '0;
            kidx_reg <= '0;
        end

        // Keystream step operands
        if (state_reg == rc4_pkg::ST_KS_READ_J)
        begin
            si_reg <= sbox_rd;
        end
        if (state_reg == rc4_pkg::ST_KS_SWAP_I)
        begin
            sj_reg <= sbox_rd;
            t_reg  <= add_sum;
        end

        // Key schedule step
        if (state_reg == rc4_pkg::ST_SCH_READ_ACC)
        begin
            acc_reg <= add_sum;
            sn_reg  <= sbox_rd;
        end
        if (state_reg == rc4_pkg::ST_SCH_SWAP_ACC)
        begin
            n_reg    <= n_reg + rc4_pkg::SBOX_ADDR_W'(1);
            kidx_reg <= kidx_last ? '0 : kidx_reg + rc4_pkg::KEY_ADDR_W'(1);
        end

        // Load the response
        if (out_load)
        begin
            byte_out_reg  <= byte_reg ^ ks;
            keystream_reg <= ks;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.byte_out       = byte_out_reg;
    assign rsp.keystream_byte = keystream_reg;

    // A response appears only from the last step of a data transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == rc4_pkg::ST_KS_SWAP_J && data_reg))
        else $error("response raised outside a data transaction");

    // The schedule leaves clean indices and an empty key
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4_pkg::ST_SCH_SWAP_ACC && n_reg == rc4_pkg::SBOX_LAST) |=>
        (i_reg == '0 && j_reg == '0 && key_count_reg == '0 && state_reg == rc4_pkg::ST_IDLE))
        else $error("key schedule did not finish cleanly");

    // Key count never passes the store size
    assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= rc4_pkg::KEY_MAX_CNT)
        else $error("key count overflow");

    // The S-box is never written while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4_pkg::ST_IDLE) |-> !sbox_we)
        else $error("S-box write while idle");

endmodule

`default_nettype wire
